@@ src/kvt_pkg.sv @@
// Package for the key/value table: opcodes, status codes, sequencer states
// and the control bundle that is broadcast along the row of cells. No dependencies.
`default_nettype none

package kvt_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int KEY_W          = 32;
	localparam int DATA_PORT_W    = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_SET    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_COMMIT
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic    compare;
		logic    commit;
		opcode_t op;
		logic    any_hit;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/kvt_if.sv @@
// Request and response channel interfaces of the key/value table.
// Depends on kvt_pkg for key and port widths.
`default_nettype none

interface kvt_req_if;
	import kvt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             opcode;
	logic signed [KEY_W-1:0] key;
	logic [DATA_PORT_W-1:0] write_data;

	modport source (output valid, output opcode, output key, output write_data, input ready);
	modport sink   (input valid, input opcode, input key, input write_data, output ready);
endinterface

interface kvt_rsp_if;
	import kvt_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic                   found;
	logic [DATA_PORT_W-1:0] read_data;

	modport source (output valid, output status, output found, output read_data, input ready);
	modport sink   (input valid, input status, input found, input read_data, output ready);
endinterface

`default_nettype wire

@@ src/kvt_cell.sv @@
// One slot of the key/value table: valid mark, key, data, match and claim flags.
// Depends on kvt_pkg; chained to its neighbor through the free-slot ripple.
`default_nettype none

module kvt_cell import kvt_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [KEY_W-1:0]      key,
	input  wire logic [DATA_WIDTH-1:0] wdata,
	input  wire logic                  taken_in,
	output logic                       taken_out,
	output logic                       hit,
	output logic                       claim,
	output logic [DATA_WIDTH-1:0]      hit_data
);

	logic                  valid_q;
	logic                  match_q;
	logic                  claim_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] data_q;

	// this slot or a lower free slot takes the insert
	assign taken_out = taken_in | ~valid_q;
	assign hit       = match_q;
	assign claim     = claim_q;
	assign hit_data  = match_q ? data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			claim_q <= 1'b0;
		end else if (ctl.compare) begin
			match_q <= valid_q && (key_q == key);
			claim_q <= !valid_q && !taken_in;
		end else if (ctl.commit) begin
			case (ctl.op)
				OP_INSERT: begin
					if (!ctl.any_hit && claim_q) valid_q <= 1'b1;
				end
				OP_DELETE: begin
					if (match_q) valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			case (ctl.op)
				OP_INSERT: begin
					if (!ctl.any_hit && claim_q) begin
						key_q  <= key;
						data_q <= wdata;
					end
				end
				OP_SET: begin
					if (match_q) data_q <= wdata;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/key_value_table.sv @@
// Top level of the key/value table: request registers, sequencer, row of cells
// and response register. Depends on kvt_pkg, kvt_if (channels) and kvt_cell.
//
//   channel | dir | payload                        | accepted when
//   --------+-----+--------------------------------+---------------------------
//   req     | in  | opcode, key, write_data        | req.valid && req.ready
//   rsp     | out | status, found, read_data       | rsp.valid && rsp.ready
//
// Each request passes through S_COMPARE, which compares the key in every cell at
// once and ripples the free-slot chain, then S_COMMIT, which commits the chosen
// slot and loads the response. The next request is taken in the commit cycle, so
// requests can follow back to back while the response register drains.
// Reset clears all valid marks at once; keys and data are undefined until written.
// A response that is not taken holds the commit cycle, and with it req.ready.
`default_nettype none

module key_value_table import kvt_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	// sequencer
	state_t state_q, state_d;
	logic   accept;
	logic   commit_go;

	// request held for the whole operation
	opcode_t               op_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [DATA_WIDTH-1:0] wdata_ext;

	// row of cells
	cell_ctl_t             ctl;
	logic [CAPACITY:0]     taken;
	logic [CAPACITY-1:0]   hit;
	logic [CAPACITY-1:0]   claim;
	logic [DATA_WIDTH-1:0] hit_data [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_any;
	logic [DATA_PORT_W-1:0] rd_port;
	logic                  any_hit;
	logic                  full;

	// response register
	logic                   rsp_valid_q;
	status_t                status_q, status_d;
	logic                   found_q;
	logic [DATA_PORT_W-1:0] read_data_q;

	// store only the low DATA_WIDTH bits of the request data; zero-extend it when DATA_WIDTH is wider
	generate
		if (DATA_WIDTH > DATA_PORT_W) begin : g_wide
			assign wdata_ext = {{(DATA_WIDTH - DATA_PORT_W){1'b0}}, req.write_data};
			assign rd_port   = rd_any[DATA_PORT_W-1:0];
		end else if (DATA_WIDTH == DATA_PORT_W) begin : g_same
			assign wdata_ext = req.write_data;
			assign rd_port   = rd_any;
		end else begin : g_narrow
			assign wdata_ext = req.write_data[DATA_WIDTH-1:0];
			assign rd_port   = {{(DATA_PORT_W - DATA_WIDTH){1'b0}}, rd_any};
		end
	endgenerate

	// take a new request when idle or in the cycle that retires the current one
	assign commit_go = (state_q == S_COMMIT) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE) || commit_go;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (accept) state_d = S_COMPARE;
			S_COMPARE: state_d = S_COMMIT;
			S_COMMIT: begin
				if (accept) state_d = S_COMPARE;
				else if (commit_go) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// hold the request until it commits
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode_t'(req.opcode);
			key_q   <= req.key;
			wdata_q <= wdata_ext;
		end
	end

	assign ctl.compare = (state_q == S_COMPARE);
	assign ctl.commit  = commit_go;
	assign ctl.op      = op_q;
	assign ctl.any_hit = any_hit;

	// free-slot ripple starts untaken at slot zero
	assign taken[0] = 1'b0;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			kvt_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.key       (key_q),
				.wdata     (wdata_q),
				.taken_in  (taken[i]),
				.taken_out (taken[i+1]),
				.hit       (hit[i]),
				.claim     (claim[i]),
				.hit_data  (hit_data[i])
			);
		end
	endgenerate

	// keys are unique, so at most one cell drives nonzero data
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | hit_data[i];
		end
	end

	assign any_hit = |hit;
	assign full    = ~|claim;

	always_comb begin
		case (op_q)
			OP_INSERT: status_d = any_hit ? ST_PRESENT : (full ? ST_FULL : ST_OK);
			default:   status_d = any_hit ? ST_OK : ST_NOT_FOUND;
		endcase
	end

	// load the response on commit, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			status_q    <= status_d;
			found_q     <= any_hit;
			read_data_q <= (op_q == OP_GET) ? rd_port : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.found     = found_q;
	assign rsp.read_data = read_data_q;

endmodule

`default_nettype wire

@@ src/kvt_checker.sv @@
// Port-level checks for the key/value table, bound to key_value_table.
// Depends on kvt_pkg for status codes and port widths.
`default_nettype none

module kvt_checker import kvt_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   req_valid,
	input wire logic                   req_ready,
	input wire logic                   rsp_valid,
	input wire logic                   rsp_ready,
	input wire logic [1:0]             rsp_status,
	input wire logic                   rsp_found,
	input wire logic [DATA_PORT_W-1:0] rsp_read_data
);

	// a pending response stays up until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// the compare cycle never takes a request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during compare cycle");

	// found and status agree
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> (rsp_status == ST_OK || rsp_status == ST_PRESENT))
		else $error("found response with miss or full status");

	a_present_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_PRESENT) |-> rsp_found)
		else $error("key-present status without found");

	// a miss returns no data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> (rsp_read_data == '0))
		else $error("miss returned nonzero data");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_found     (rsp.found),
	.rsp_read_data (rsp.read_data)
);

`default_nettype wire

@@ tb/sv/key_value_table_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for key_value_table: directed and random requests on
// the req channel, each response checked against a predicted table model.
// Depends on kvt_pkg, kvt_if and the key_value_table RTL.

module key_value_table_test;
	import kvt_pkg::*;

	localparam int SLOTS           = CAPACITY_DEF;
	localparam int DW              = DATA_WIDTH_DEF;
	localparam int POOL_SIZE       = 20;
	localparam int IDLE_LIMIT      = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 8;

	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

	typedef struct packed {
		status_t                status;
		logic                   found;
		logic [DATA_PORT_W-1:0] read_data;
	} kv_result_t;

	// receiver ready patterns
	typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	// opcode mixes for the random traffic: fill pushes the table to full,
	// drain empties it, balanced gives all four opcodes equal weight
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

	logic clk;
	logic arst_n;

	kvt_req_if req_ch ();
	kvt_rsp_if rsp_ch ();

	key_value_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the table
	logic                 slot_used [SLOTS];
	logic [KEY_W-1:0]     slot_key  [SLOTS];
	logic [DW-1:0]        slot_data [SLOTS];

	kv_result_t           pending_results [$];
	logic [KEY_W-1:0]     key_pool [POOL_SIZE];

	int          error_count = 0;
	int          burst_left  = 0;
	bit          allow_gaps  = 1'b1;
	int          hold_requests = 0;
	int          holds_started = 0;
	int          hold_left   = 0;
	rx_pattern_t rx_mode     = RX_ALWAYS;
	int          rx_mode_left = 0;
	int unsigned rx_phase    = 0;
	int          idle_cycles = 0;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one request to the shadow table and return the response it must
	// produce. Match and free-slot search both scan from slot 0 upward.
	function automatic kv_result_t predict_table_op(input opcode_t op,
			input logic [KEY_W-1:0] k, input logic [DATA_PORT_W-1:0] wd);
		int         hit;
		int         free_idx;
		kv_result_t r;
		hit      = -1;
		free_idx = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && slot_used[i] && slot_key[i] == k)
				hit = i;
			if (free_idx < 0 && !slot_used[i])
				free_idx = i;
		end
		r.status    = ST_OK;
		r.found     = (hit >= 0);
		r.read_data = '0;
		case (op)
			OP_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_PRESENT;
				end else if (free_idx < 0) begin
					r.status = ST_FULL;
				end else begin
					slot_used[free_idx] = 1'b1;
					slot_key[free_idx]  = k;
					slot_data[free_idx] = wd[DW-1:0];
				end
			end
			OP_DELETE: begin
				if (hit >= 0)
					slot_used[hit] = 1'b0;
				else
					r.status = ST_NOT_FOUND;
			end
			OP_GET: begin
				if (hit >= 0)
					r.read_data = DATA_PORT_W'(slot_data[hit]);
				else
					r.status = ST_NOT_FOUND;
			end
			default: begin
				if (hit >= 0)
					slot_data[hit] = wd[DW-1:0];
				else
					r.status = ST_NOT_FOUND;
			end
		endcase
		return r;
	endfunction

	// Send one request. Inputs change only at the falling edge; acceptance is
	// seen at the rising edge. Between bursts, when gaps are allowed, usually drop
	// valid for a random gap and drive junk payload so that the block must ignore it.
	task automatic send_request(input opcode_t op, input logic [KEY_W-1:0] k,
			input logic [DATA_PORT_W-1:0] wd, output kv_result_t predicted);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			if (allow_gaps && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 9);
				req_ch.valid = 1'b0;
				repeat (gap) begin
					req_ch.opcode     = 2'($urandom);
					req_ch.key        = $urandom;
					req_ch.write_data = $urandom;
					@(negedge clk);
				end
			end
			// mostly short bursts, now and then a long gap-free stretch
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		req_ch.valid      = 1'b1;
		req_ch.opcode     = op;
		req_ch.key        = k;
		req_ch.write_data = wd;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = predict_table_op(op, k, wd);
		pending_results.push_back(predicted);
		burst_left--;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic opcode_t pick_opcode(input traffic_mix_t mix);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (roll < 60) ? OP_INSERT : (roll < 70) ? OP_DELETE
				: (roll < 85) ? OP_GET : OP_SET;
			MIX_DRAIN: return (roll < 15) ? OP_INSERT : (roll < 65) ? OP_DELETE
				: (roll < 85) ? OP_GET : OP_SET;
			default:   return opcode_t'(roll[1:0]);
		endcase
	endfunction

	task automatic apply_reset();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	endtask

	// Extremes of key and data, every opcode, and each hit/miss outcome.
	task automatic test_basic_ops();
		kv_result_t r;
		send_request(OP_INSERT, KEY_MIN, 32'h0000_0000, r);
		send_request(OP_INSERT, KEY_MAX, 32'hffff_ffff, r);
		send_request(OP_INSERT, 32'h0000_0000, 32'h5a5a_a5a5, r);
		send_request(OP_INSERT, 32'hffff_ffff, 32'h1234_5678, r);
		// duplicate key: refused, stored data kept
		send_request(OP_INSERT, KEY_MIN, 32'hdead_beef, r);
		send_request(OP_GET, KEY_MIN, 32'hffff_ffff, r);
		send_request(OP_GET, KEY_MAX, 32'h0000_0000, r);
		send_request(OP_GET, 32'h0000_0001, 32'h0000_0000, r);
		send_request(OP_SET, 32'h0000_0000, 32'hffff_ffff, r);
		send_request(OP_SET, 32'h0000_0001, 32'h0000_0000, r);
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000, r);
		send_request(OP_DELETE, KEY_MAX, 32'h0000_0000, r);
		send_request(OP_DELETE, KEY_MAX, 32'h0000_0000, r);
		send_request(OP_GET, KEY_MAX, 32'h0000_0000, r);
		send_request(OP_SET, KEY_MAX, 32'h0000_0000, r);
	endtask

	// Fill every slot, hit the full status, then free a slot in the middle
	// and reuse it.
	task automatic test_full_table();
		kv_result_t  r;
		logic [KEY_W-1:0] k;
		k = 32'h1000_0000;
		do begin
			send_request(OP_INSERT, k, ~k, r);
			k++;
		end while (r.status != ST_FULL);
		// full table still reports a present key as present
		send_request(OP_INSERT, KEY_MIN, 32'h0, r);
		send_request(OP_DELETE, 32'h1000_0005, 32'h0, r);
		send_request(OP_INSERT, 32'h2000_0000, 32'hcafe_f00d, r);
		send_request(OP_GET, 32'h2000_0000, 32'h0, r);
		send_request(OP_INSERT, 32'h2000_0001, 32'h0, r);
	endtask

	// Random traffic over a small key pool so that hits, misses, full and
	// empty all come up often. Pick a new random opcode mix every 100 requests.
	task automatic test_random_traffic(input int count);
		kv_result_t   r;
		traffic_mix_t mix;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0)
				mix = traffic_mix_t'($urandom_range(0, 2));
			send_request(pick_opcode(mix), pick_key(), $urandom, r);
		end
	endtask

	// Hold the receiver off for a long stretch while requests keep coming
	// with no gaps, so that the block backs up and stalls req.
	task automatic test_backpressure();
		kv_result_t r;
		allow_gaps = 1'b0;
		hold_requests++;
		for (int n = 0; n < 48; n++)
			send_request(opcode_t'($urandom_range(0, 3)), pick_key(), $urandom, r);
		allow_gaps = 1'b1;
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_INSERT;
		req_ch.key        = '0;
		req_ch.write_data = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_data[i] = '0;
		end
		// pool with the key extremes and random patterns
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		apply_reset();
		test_basic_ops();
		test_full_table();
		test_random_traffic(400);
		test_backpressure();
		test_random_traffic(400);

		// drop valid and let every response come back
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: change ready at the falling edge. A hold-off request from the
	// test holds ready low for a counted stretch; otherwise follow a pattern
	// that is chosen at random and switches when its random run length runs out.
	always @(negedge clk) begin
		rx_phase++;
		if (holds_started != hold_requests) begin
			holds_started = hold_requests;
			hold_left     = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_pattern_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 96);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_ALWAYS:   rsp_ch.ready = 1'b1;
				RX_RANDOM:   rsp_ch.ready = 1'($urandom_range(0, 1));
				RX_SPARSE:   rsp_ch.ready = ($urandom_range(0, 3) == 0);
				default:     rsp_ch.ready = (rx_phase % 3 != 0);
			endcase
		end
	end

	// Check every accepted response against the oldest prediction.
	always @(posedge clk) begin : check_responses
		kv_result_t want;
		kv_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status    = status_t'(rsp_ch.status);
			got.found     = rsp_ch.found;
			got.read_data = rsp_ch.read_data;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected response status=%0d found=%0b read_data=%h",
					$time, got.status, got.found, got.read_data);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.found !== want.found
						|| got.read_data !== want.read_data) begin
					error_count++;
					$display("%0t: response mismatch: expected status=%0d found=%0b read_data=%h,",
						$time, want.status, want.found, want.read_data,
						" got status=%0d found=%0b read_data=%h",
						got.status, got.found, got.read_data);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request or response accepted for %0d cycles",
					$time, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
